/* sv/ccfr_pkg.sv */
// Shared types and constants of the framed byte receiver.
// Depends on nothing; ccfr_out_skid and crc_checked_frame_receiver import it.
package ccfr_pkg;

   localparam int LENGTH_BITS = 16;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [7:0]  START_MARKER_RESET = 8'hAA;
   localparam logic [7:0]  END_MARKER_RESET   = 8'hBB;
   localparam logic [15:0] MAX_LENGTH_RESET   = 16'd1024;
   localparam logic [31:0] POLYNOMIAL_RESET   = 32'h04C1_1DB7;

   localparam logic [1:0] CSR_START_MARKER = 2'd0;
   localparam logic [1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH   = 2'd2;
   localparam logic [1:0] CSR_POLYNOMIAL   = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_END = 2'd1;
   localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

   typedef enum logic [2:0] {
      PH_WAIT    = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC     = 3'd5,
      PH_END     = 3'd6
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_value;
      logic [15:0] payload_offset;
      logic [7:0]  frame_type;
      logic [15:0] frame_length;
      logic [1:0]  frame_status;
   } rsp_item_type;

endpackage

/* sv/ccfr_channels.sv */
// Valid/ready channel interfaces of the framed byte receiver.
// Request carries one received byte; response carries one result item.
interface ccfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_data;

   modport source (output valid, output rx_data, input ready);
   modport sink (input valid, input rx_data, output ready);
endinterface

interface ccfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_value;
   logic [15:0] payload_offset;
   logic [7:0]  frame_type;
   logic [15:0] frame_length;
   logic [1:0]  frame_status;

   modport source (output valid, output kind, output payload_value, output payload_offset,
                   output frame_type, output frame_length, output frame_status,
                   input ready);
   modport sink (input valid, input kind, input payload_value, input payload_offset,
                 input frame_type, input frame_length, input frame_status,
                 output ready);
endinterface

/* sv/ccfr_crc_update.sv */
// One-byte MSB-first CRC-32 update with a programmable generator.
// Depends on nothing beyond plain logic.
module ccfr_crc_update (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   input  logic [31:0] poly,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] acc;
      acc = crc_cur ^ {data_byte, 24'h000000};
      // shift out one bit per step, folding in the generator on a carry
      for (int i = 0; i < 8; i++) begin
         if (acc[31]) begin
            acc = {acc[30:0], 1'b0} ^ poly;
         end else begin
            acc = {acc[30:0], 1'b0};
         end
      end
      crc_next = acc;
   end

endmodule

/* sv/ccfr_out_skid.sv */
// Result register with a one-entry skid stage behind it.
// Uses rsp_item_type from ccfr_pkg.
module ccfr_out_skid
   import ccfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rsp_item_type in_item,
   output logic         in_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         out_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
   assign out_free  = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         // drain the skid entry first; a new item only arrives while it is empty
         out_valid_in  = skid_valid_ff || in_valid;
         out_item_in   = skid_valid_ff ? skid_item_ff : in_item;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result pushed while skid entry occupied");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && out_item_ff == $past(skid_item_ff))
      else $error("skid entry not moved into result register");
`endif

endmodule

/* sv/crc_checked_frame_receiver.sv */
// Framed byte receiver with CRC-32 check over the payload.
// Request channel req_chan: one received byte per transfer (rx_data).
// Response channel rsp_chan: one result per payload byte (kind 0) and one
// status per frame at the end byte (kind 1: 0 ok, 1 bad end, 2 CRC mismatch).
// Frame: start, type, length low, length high, payload, CRC LSB first, end.
// Frames longer than max_payload_length are dropped without any result.
// Configuration: csr_we writes csr_wdata into register csr_index
// (0 start marker, 1 end marker, 2 max payload length, 3 polynomial);
// write only while no frame is in flight.
// Throughput: one byte per cycle while req_chan.ready is high; the parser state
// and CRC update in the cycle of the transfer, through an 8-step XOR network.
// Results: each is registered in the result register, or the skid stage when that is full, before rsp_chan offers it.
// Stall: a result register and a one-entry skid stage sit at the output;
// req_chan.ready falls only once both are full, so at most two results wait.
// Reset (synchronous, active high): registers return to their defaults,
// the parser waits for a start byte and any waiting result is dropped.
module crc_checked_frame_receiver
   import ccfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ccfr_req_if.sink    req_chan,
   ccfr_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [7:0]  start_marker_ff;
   logic [7:0]  end_marker_ff;
   logic [15:0] max_length_ff;
   logic [31:0] polynomial_ff;

   phase_type               phase_ff, phase_in;
   logic [15:0]             byte_counter_ff, byte_counter_in;
   logic [LENGTH_BITS-1:0]  length_ff, length_in;
   logic [7:0]              type_byte_ff, type_byte_in;
   logic [31:0]             running_crc_ff, running_crc_in;
   logic [31:0]             received_crc_ff, received_crc_in;
   logic                    crc_failed_ff, crc_failed_in;

   logic                    accept;
   logic                    rx_ready;
   logic [7:0]              rx;
   logic [31:0]             crc_next;
   logic [15:0]             count_inc;
   logic [LENGTH_BITS-1:0]  length_full;
   logic [31:0]             crc_word;
   logic                    res_valid;
   rsp_item_type            res_item;
   rsp_item_type            out_item;

   assign rx             = req_chan.rx_data;
   assign req_chan.ready = rx_ready;
   assign accept         = req_chan.valid && rx_ready;
   assign count_inc      = byte_counter_ff + 16'd1;
   assign length_full    = LENGTH_BITS'({rx, length_ff[7:0]});
   assign crc_word       = received_crc_ff | ({24'h000000, rx} << {byte_counter_ff[1:0], 3'b000});

   ccfr_crc_update u_crc (
      .crc_cur   (running_crc_ff),
      .data_byte (rx),
      .poly      (polynomial_ff),
      .crc_next  (crc_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
         max_length_ff   <= MAX_LENGTH_RESET;
         polynomial_ff   <= POLYNOMIAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata[7:0];
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata[7:0];
            CSR_MAX_LENGTH:   max_length_ff   <= csr_wdata[15:0];
            CSR_POLYNOMIAL:   polynomial_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WAIT;
         byte_counter_ff <= '0;
         length_ff       <= '0;
         type_byte_ff    <= '0;
         running_crc_ff  <= CRC_INIT;
         received_crc_ff <= '0;
         crc_failed_ff   <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         byte_counter_ff <= byte_counter_in;
         length_ff       <= length_in;
         type_byte_ff    <= type_byte_in;
         running_crc_ff  <= running_crc_in;
         received_crc_ff <= received_crc_in;
         crc_failed_ff   <= crc_failed_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      byte_counter_in = byte_counter_ff;
      length_in       = length_ff;
      type_byte_in    = type_byte_ff;
      running_crc_in  = running_crc_ff;
      received_crc_in = received_crc_ff;
      crc_failed_in   = crc_failed_ff;

      res_valid               = 1'b0;
      res_item.kind           = KIND_PAYLOAD;
      res_item.payload_value  = rx;
      res_item.payload_offset = byte_counter_ff;
      res_item.frame_type     = type_byte_ff;
      res_item.frame_length   = 16'(length_ff);
      res_item.frame_status   = STATUS_OK;

      if (accept) begin
         case (phase_ff)
            PH_TYPE: begin
               if (rx == start_marker_ff) begin
                  // repeated start byte: restart, it counts as the new start
                  byte_counter_in = '0;
                  length_in       = '0;
                  type_byte_in    = '0;
                  running_crc_in  = CRC_INIT;
                  received_crc_in = '0;
                  crc_failed_in   = 1'b0;
               end else begin
                  type_byte_in = rx;
                  phase_in     = PH_LEN_LO;
               end
            end
            PH_LEN_LO: begin
               length_in = LENGTH_BITS'(rx);
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in       = length_full;
               byte_counter_in = '0;
               running_crc_in  = CRC_INIT;
               if (16'(length_full) > max_length_ff) begin
                  phase_in = PH_WAIT;
               end else if (length_full == '0) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               res_valid      = 1'b1;
               running_crc_in = crc_next;
               if (count_inc >= 16'(length_ff)) begin
                  byte_counter_in = '0;
                  phase_in        = PH_CRC;
               end else begin
                  byte_counter_in = count_inc;
               end
            end
            PH_CRC: begin
               received_crc_in = crc_word;
               if (byte_counter_ff[1:0] == 2'd3) begin
                  crc_failed_in   = (crc_word != running_crc_ff);
                  byte_counter_in = '0;
                  phase_in        = PH_END;
               end else begin
                  byte_counter_in = count_inc;
               end
            end
            PH_END: begin
               res_valid               = 1'b1;
               res_item.kind           = KIND_STATUS;
               res_item.payload_value  = '0;
               res_item.payload_offset = '0;
               // a bad end byte outranks a CRC mismatch
               if (rx != end_marker_ff) begin
                  res_item.frame_status = STATUS_BAD_END;
               end else if (crc_failed_ff) begin
                  res_item.frame_status = STATUS_BAD_CRC;
               end else begin
                  res_item.frame_status = STATUS_OK;
               end
               phase_in = PH_WAIT;
            end
            default: begin
               byte_counter_in = '0;
               length_in       = '0;
               type_byte_in    = '0;
               running_crc_in  = CRC_INIT;
               received_crc_in = '0;
               crc_failed_in   = 1'b0;
               phase_in        = (rx == start_marker_ff) ? PH_TYPE : PH_WAIT;
            end
         endcase
      end
   end

   ccfr_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_item   (res_item),
      .in_ready  (rx_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.kind           = out_item.kind;
   assign rsp_chan.payload_value  = out_item.payload_value;
   assign rsp_chan.payload_offset = out_item.payload_offset;
   assign rsp_chan.frame_type     = out_item.frame_type;
   assign rsp_chan.frame_length   = out_item.frame_length;
   assign rsp_chan.frame_status   = out_item.frame_status;

`ifndef ASSERT_OFF
   a_crc_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CRC |-> byte_counter_ff < 16'd4)
      else $error("CRC byte count out of range");
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> byte_counter_ff < 16'(length_ff))
      else $error("payload offset beyond announced length");
   a_status_offered: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_END |=> rsp_chan.valid && phase_ff == PH_WAIT)
      else $error("end byte gave no status result");
`endif

endmodule
